// ===== rtl/spi_clock_divider_calc_core_defines.svh =====
// Assertion macros shared by the serial clock divider calculator RTL.
`ifndef SPI_CLOCK_DIVIDER_CALC_CORE_DEFINES_SVH
`define SPI_CLOCK_DIVIDER_CALC_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define SCDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define SCDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/scdc_pkg.sv =====
// Shared types and constants for the serial clock divider calculator.
`default_nettype none

package scdc_pkg;

    localparam int SRC_W     = 32;
    localparam int DVD_W     = 31;
    localparam int DIV_STEPS = DVD_W;
    localparam int HP_W      = 16;
    localparam int ACT_W     = 31;

    localparam logic [SRC_W-1:0] SOURCE_HZ_RESET = 32'd50000000;
    localparam logic [HP_W-1:0]  HP_MAX          = 16'hFFFF;

    // One request as it travels down a division chain.
    typedef struct packed {
        logic             valid;
        logic             bad;
        logic [SRC_W-1:0] rem;
        logic [DVD_W-1:0] quo;
        logic [SRC_W-1:0] divisor;
        logic [SRC_W-1:0] side;
    } div_lane_t;

endpackage

`default_nettype wire

// ===== rtl/scdc_div_cell.sv =====
// One restoring division step: yields one quotient bit per cell.
`default_nettype none

module scdc_div_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire scdc_pkg::div_lane_t lane_in,
    output scdc_pkg::div_lane_t      lane_out
);

    scdc_pkg::div_lane_t lane_reg;
    scdc_pkg::div_lane_t lane_next;

    logic [scdc_pkg::SRC_W:0]   shifted;
    logic [scdc_pkg::SRC_W+1:0] diff;
    logic                       fits;

    always_comb begin
        shifted = {lane_in.rem, lane_in.quo[scdc_pkg::DVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, lane_in.divisor};
        fits    = ~diff[scdc_pkg::SRC_W+1];

        lane_next         = lane_in;
        lane_next.rem     = fits ? diff[scdc_pkg::SRC_W-1:0] : shifted[scdc_pkg::SRC_W-1:0];
        lane_next.quo     = {lane_in.quo[scdc_pkg::DVD_W-2:0], fits};
    end

    // Only the valid bit is cleared by reset; the data fields follow it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ===== rtl/scdc_div_chain.sv =====
// A row of division cells that turns a dividend into a full quotient.
`default_nettype none

module scdc_div_chain (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire scdc_pkg::div_lane_t lane_in,
    output scdc_pkg::div_lane_t      lane_out
);

    scdc_pkg::div_lane_t link [scdc_pkg::DIV_STEPS+1];

    assign link[0] = lane_in;

    for (genvar i = 0; i < scdc_pkg::DIV_STEPS; i++) begin : g_cell
        scdc_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .lane_in (link[i]),
            .lane_out(link[i+1])
        );
    end

    assign lane_out = link[scdc_pkg::DIV_STEPS];

endmodule

`default_nettype wire

// ===== rtl/spi_clock_divider_calc_core.sv =====
// Top level of the serial clock divider calculator.
`default_nettype none

`include "spi_clock_divider_calc_core_defines.svh"

// Each request carries a target serial clock rate; the block returns the half-period
// divider ceil(source_hz / (2 * target_hz)) and the rate that divider achieves,
// source_hz divided by twice the divider, or status 1 with zeroed fields when the request
// cannot be met. A new request is taken every cycle unless the pipeline is halted; it passes
// through two rows of 31 single-bit division cells, the first for the divider and the second
// for the achieved rate, followed by the output register. The pipeline only halts
// when a result reaches the end while the previous one has not yet been taken.
// source_hz resets to 50 MHz and should only be rewritten while no request is in flight.
module spi_clock_divider_calc_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [scdc_pkg::SRC_W-1:0] cfg_data,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [scdc_pkg::SRC_W-1:0] s_target_hz,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_status,
    output logic [scdc_pkg::HP_W-1:0]       m_half_cycles,
    output logic [scdc_pkg::ACT_W-1:0]      m_achieved_hz
);

    logic [scdc_pkg::SRC_W-1:0] source_hz_reg;

    scdc_pkg::div_lane_t c1_in, c1_out, c2_in, c2_out;

    logic                        en;
    logic [scdc_pkg::SRC_W-1:0]  src_less_one;
    logic [scdc_pkg::HP_W-1:0]   hp;
    logic                        hp_ovf;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_status_reg;
    logic [scdc_pkg::HP_W-1:0]   m_half_cycles_reg;
    logic [scdc_pkg::ACT_W-1:0]  m_achieved_hz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_hz_reg <= scdc_pkg::SOURCE_HZ_RESET;
        end else if (cfg_valid && cfg_ready) begin
            source_hz_reg <= cfg_data;
        end
    end

    // Halt everything only when a finished result would overwrite one still waiting.
    assign en      = !(c2_out.valid && m_valid_reg && !m_ready);
    assign s_ready = en;

    // ceil(S / 2T) is floor(((S - 1) >> 1) / T) + 1 once S is known to be non-zero.
    always_comb begin
        src_less_one  = source_hz_reg - scdc_pkg::SRC_W'(1);
        c1_in.valid   = s_valid;
        c1_in.bad     = (source_hz_reg == '0) || (s_target_hz == '0)
                        || (s_target_hz > {1'b0, source_hz_reg[scdc_pkg::SRC_W-1:1]});
        c1_in.rem     = '0;
        c1_in.quo     = src_less_one[scdc_pkg::SRC_W-1:1];
        c1_in.divisor = s_target_hz;
        c1_in.side    = source_hz_reg;
    end

    scdc_div_chain u_chain_hp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .lane_in (c1_in),
        .lane_out(c1_out)
    );

    // The achieved rate is floor((S >> 1) / divider); the divisor lane keeps the divider.
    always_comb begin
        hp_ovf        = c1_out.quo > scdc_pkg::DVD_W'(scdc_pkg::HP_MAX - scdc_pkg::HP_W'(1));
        hp            = c1_out.quo[scdc_pkg::HP_W-1:0] + scdc_pkg::HP_W'(1);
        c2_in.valid   = c1_out.valid;
        c2_in.bad     = c1_out.bad || hp_ovf;
        c2_in.rem     = '0;
        c2_in.quo     = c1_out.side[scdc_pkg::SRC_W-1:1];
        c2_in.divisor = {{(scdc_pkg::SRC_W-scdc_pkg::HP_W){1'b0}}, hp};
        c2_in.side    = '0;
    end

    scdc_div_chain u_chain_rate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .lane_in (c2_in),
        .lane_out(c2_out)
    );

    always_comb begin
        if (c2_out.valid && en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    logic final_bad;
    assign final_bad = c2_out.bad || (c2_out.quo == '0);

    always_ff @(posedge aclk) begin
        if (c2_out.valid && en) begin
            m_status_reg      <= final_bad;
            m_half_cycles_reg <= final_bad ? '0 : c2_out.divisor[scdc_pkg::HP_W-1:0];
            m_achieved_hz_reg <= final_bad ? '0 : c2_out.quo;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_half_cycles = m_half_cycles_reg;
    assign m_achieved_hz = m_achieved_hz_reg;

    `SCDC_ASSERT(a_bad_zeroed, (m_valid && m_status) |-> (m_half_cycles == '0 && m_achieved_hz == '0), "Rejected request carries non-zero fields")
    `SCDC_ASSERT(a_ok_nonzero, (m_valid && !m_status) |-> (m_half_cycles != '0 && m_achieved_hz != '0), "Accepted request has a zero divider or rate")
    `SCDC_ASSERT(a_stall_holds, (c2_out.valid && !en) |=> c2_out.valid, "Finished request lost while the pipeline was halted")
    `SCDC_ASSERT_ALWAYS(a_reset_idle, !$past(aresetn) |-> !m_valid, "Result presented straight after reset")

endmodule

`default_nettype wire

// ===== tb/spi_clock_divider_calc_core_checker.sv =====
// Checker for the serial clock divider calculator: predicts each result and compares it.
`default_nettype none

module spi_clock_divider_calc_core_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [scdc_pkg::SRC_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic [scdc_pkg::SRC_W-1:0] s_target_hz,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic                       m_status,
    input  wire logic [scdc_pkg::HP_W-1:0]  m_half_cycles,
    input  wire logic [scdc_pkg::ACT_W-1:0] m_achieved_hz,
    output int                              mismatches,
    output int                              outstanding,
    output int                              valid_dividers,
    output int                              rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       status;
        logic [scdc_pkg::HP_W-1:0]  half_cycles;
        logic [scdc_pkg::ACT_W-1:0] achieved_hz;
    } divider_result_t;

    typedef struct packed {
        logic [scdc_pkg::SRC_W-1:0] target_hz;
        logic [scdc_pkg::SRC_W-1:0] source_hz;
        divider_result_t            result;
    } divider_expect_t;

    divider_expect_t            pending_dividers[$];
    logic [scdc_pkg::SRC_W-1:0] source_copy;

    function automatic divider_result_t predict_divider(input logic [scdc_pkg::SRC_W-1:0] src,
                                                        input logic [scdc_pkg::SRC_W-1:0] tgt);
        logic [63:0]                twice_tgt;
        logic [63:0]                hp;
        logic [scdc_pkg::SRC_W-1:0] achieved;
        divider_result_t            r;
        r.status      = 1'b1;
        r.half_cycles = '0;
        r.achieved_hz = '0;
        if (src != '0 && tgt != '0 && tgt <= (src >> 1)) begin
            twice_tgt = {32'd0, tgt} << 1;
            // Ceiling division: round the half period up so the rate never exceeds the target.
            hp = ({32'd0, src} + twice_tgt - 64'd1) / twice_tgt;
            if (hp != 64'd0 && hp <= {48'd0, scdc_pkg::HP_MAX}) begin
                achieved = src / (hp[scdc_pkg::SRC_W-1:0] << 1);
                if (achieved != '0) begin
                    r.status      = 1'b0;
                    r.half_cycles = hp[scdc_pkg::HP_W-1:0];
                    r.achieved_hz = achieved[scdc_pkg::ACT_W-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want, input divider_expect_t ctx);
        $display("[%0t] MISMATCH %s: got %0d, want %0d (target %0d Hz, source %0d Hz)",
                 $realtime, what, got, want, ctx.target_hz, ctx.source_hz);
        mismatches++;
    endtask

    initial begin
        mismatches     = 0;
        outstanding    = 0;
        valid_dividers = 0;
        rejected       = 0;
        source_copy    = scdc_pkg::SOURCE_HZ_RESET;
    end

    always @(posedge aclk) begin
        divider_expect_t head;
        if (!aresetn) begin
            source_copy = scdc_pkg::SOURCE_HZ_RESET;
            pending_dividers.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                source_copy = cfg_data;
            if (m_valid && m_ready) begin
                if (pending_dividers.size() == 0) begin
                    head = '0;
                    report_mismatch("result with no request waiting", 32'(m_half_cycles),
                                    32'd0, head);
                end else begin
                    head = pending_dividers.pop_front();
                    if (m_status !== head.result.status)
                        report_mismatch("status", 32'(m_status), 32'(head.result.status), head);
                    if (m_half_cycles !== head.result.half_cycles)
                        report_mismatch("half_cycles", 32'(m_half_cycles),
                                        32'(head.result.half_cycles), head);
                    if (m_achieved_hz !== head.result.achieved_hz)
                        report_mismatch("achieved_hz", 32'(m_achieved_hz),
                                        32'(head.result.achieved_hz), head);
                    if (head.result.status)
                        rejected <= rejected + 1;
                    else
                        valid_dividers <= valid_dividers + 1;
                end
            end
            if (s_valid && s_ready) begin
                head.target_hz = s_target_hz;
                head.source_hz = source_copy;
                head.result    = predict_divider(source_copy, s_target_hz);
                pending_dividers.push_back(head);
            end
        end
        outstanding <= pending_dividers.size();
    end

endmodule

`default_nettype wire

// ===== tb/spi_clock_divider_calc_core_tb.sv =====
// Testbench top for the serial clock divider calculator: stimulus, back-pressure and verdict.
`default_nettype none

module spi_clock_divider_calc_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 70;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 80;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [scdc_pkg::SRC_W-1:0] cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [scdc_pkg::SRC_W-1:0] s_target_hz;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_status;
    logic [scdc_pkg::HP_W-1:0]  m_half_cycles;
    logic [scdc_pkg::ACT_W-1:0] m_achieved_hz;

    int mismatches;
    int outstanding;
    int valid_dividers;
    int rejected;
    int cycles;
    int burst_left;
    int requests_sent;
    int source_settings;
    bit long_hold_req;

    spi_clock_divider_calc_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_target_hz   (s_target_hz),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_half_cycles (m_half_cycles),
        .m_achieved_hz (m_achieved_hz)
    );

    spi_clock_divider_calc_core_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_hz    (s_target_hz),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_half_cycles  (m_half_cycles),
        .m_achieved_hz  (m_achieved_hz),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .valid_dividers (valid_dividers),
        .rejected       (rejected)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles,
                     outstanding);
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one request; the sender works in bursts, idling for a random gap between them when allow_gap is set.
    task automatic send_target(input logic [scdc_pkg::SRC_W-1:0] tgt, input bit allow_gap);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (allow_gap && gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 60);
        end
        s_valid     <= 1'b1;
        s_target_hz <= tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        requests_sent++;
    endtask

    // Lets the pipeline drain completely before anything else happens.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_source(input logic [scdc_pkg::SRC_W-1:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        source_settings++;
    endtask

    // Mostly well-formed targets, with a share around each rejection boundary.
    function automatic logic [scdc_pkg::SRC_W-1:0] pick_target(
            input logic [scdc_pkg::SRC_W-1:0] src);
        logic [scdc_pkg::SRC_W-1:0] half_src;
        logic [scdc_pkg::SRC_W-1:0] t;
        int                         pick;
        half_src = src >> 1;
        pick     = $urandom_range(0, 9);
        case (pick)
            0, 1: t = $urandom;
            2: t = half_src + $urandom_range(0, 2) - 1;
            3: t = src / 32'd131070 + $urandom_range(0, 4) - 2;
            4: t = 32'd1 << $urandom_range(0, 31);
            5: begin
                pick = $urandom_range(0, 2);
                t = (pick == 0) ? 32'd0 : ((pick == 1) ? 32'd1 : 32'hFFFF_FFFF);
            end
            default: t = (half_src == 0) ? $urandom : $urandom_range(half_src, 1);
        endcase
        return t;
    endfunction

    // Result-side back-pressure with a pattern of its own, plus one long hold on request.
    initial begin
        ready_mode_t mode;
        int          mode_left;
        int          tick;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        tick      = 0;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    RDY_ALWAYS:  m_ready <= 1'b1;
                    RDY_RANDOM:  m_ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= (tick % 5 != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        logic [scdc_pkg::SRC_W-1:0] source_plan[12];
        logic [scdc_pkg::SRC_W-1:0] src;
        cycles          = 0;
        burst_left      = 0;
        requests_sent   = 0;
        source_settings = 0;
        long_hold_req   = 1'b0;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_target_hz <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset source of 50 MHz first.
        send_target(32'd0, 1'b1);
        send_target(32'd1, 1'b1);
        send_target(32'd381, 1'b1);          // divider just above its 16-bit range
        send_target(32'd382, 1'b1);          // divider just inside it
        send_target(32'd25_000_000, 1'b1);   // fastest legal rate
        send_target(32'd25_000_001, 1'b1);   // one above half the source
        send_target(32'hFFFF_FFFF, 1'b1);
        send_target(32'd400_000, 1'b1);
        send_target(32'd16_666_667, 1'b1);
        // A source of 3 Hz gives a divider of 2 whose achieved rate rounds to zero.
        write_source(32'd3);
        send_target(32'd1, 1'b1);
        send_target(32'd2, 1'b1);
        write_source(32'd0);
        send_target(32'd1, 1'b1);
        send_target(32'hFFFF_FFFF, 1'b1);
        write_source(32'hFFFF_FFFF);
        send_target(32'h7FFF_FFFF, 1'b1);
        send_target(32'h8000_0000, 1'b1);
        send_target(32'd32768, 1'b1);
        send_target(32'd32769, 1'b1);
        send_target(32'd1, 1'b1);
        write_source(32'd4);
        send_target(32'd2, 1'b1);
        send_target(32'd1, 1'b1);

        source_plan[0]  = scdc_pkg::SOURCE_HZ_RESET;
        source_plan[1]  = 32'hFFFF_FFFF;
        source_plan[2]  = 32'd0;
        source_plan[3]  = 32'd1;
        source_plan[4]  = 32'd2;
        source_plan[5]  = 32'd3;
        source_plan[6]  = 32'd131070;
        source_plan[7]  = 32'd131071;
        source_plan[8]  = 32'd100_000_000;
        source_plan[9]  = $urandom;
        source_plan[10] = $urandom_range(1_000_000, 1);
        source_plan[11] = $urandom;

        for (int p = 0; p < 12; p++) begin
            src = source_plan[p];
            write_source(src);
            if (p == 0) begin
                // Hold results off while requests keep coming, so the pipeline fills up.
                long_hold_req = 1'b1;
                for (int i = 0; i < 150; i++)
                    send_target(pick_target(src), 1'b0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 8 && i == PHASE_ITEMS / 2)
                    wait_until_drained();
                send_target(pick_target(src), 1'b1);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests over %0d source clock settings", requests_sent,
                 source_settings + 1);
        $display("Results: %0d usable dividers, %0d rejected requests", valid_dividers,
                 rejected);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/scdc_pkg.sv
rtl/scdc_div_cell.sv
rtl/scdc_div_chain.sv
rtl/spi_clock_divider_calc_core.sv
tb/spi_clock_divider_calc_core_checker.sv
tb/spi_clock_divider_calc_core_tb.sv
